// ===== rtl/blpw_pkg.sv =====
// Package for the Bresenham line pixel writer: shared types, register
// indexes and fixed widths. No dependencies.
`default_nettype none

package blpw_pkg;

  // Width of the APB address bus: five 32-bit registers at byte offsets 0..16.
  localparam int PADDR_W = 5;
  // Translated coordinate width; holds 16-bit point + 16-bit shift + offset.
  localparam int SUM_W   = 18;
  // Depth of the queue between the stepper and the address pipeline.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    REG_X_SHIFT    = 3'd0,
    REG_Y_SHIFT    = 3'd1,
    REG_ROW_BYTES  = 3'd2,
    REG_PIXEL_BITS = 3'd3,
    REG_FRAME_BASE = 3'd4
  } reg_idx_t;

  // Live configuration seen by the address pipeline.
  typedef struct packed {
    logic [15:0] x_shift;
    logic [15:0] y_shift;
    logic [15:0] row_bytes;
    logic [5:0]  pixel_bits;
    logic [31:0] frame_base;
  } cfg_t;

  // One raster point as produced by the stepper (coordinates two's complement).
  typedef struct packed {
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [31:0] color;
    logic        last;
    logic        idle;
  } point_t;

endpackage

`default_nettype wire

// ===== rtl/blpw_if.sv =====
// Valid/ready channel interfaces for the line pixel writer: the command
// channel and the pixel channel. No dependencies.
`default_nettype none

interface blpw_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [15:0] end_x;
  logic [15:0] end_y;
  logic [31:0] line_color;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

interface blpw_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] pixel_x;
  logic [16:0] pixel_y;
  logic [31:0] pixel_address;
  logic [31:0] pixel_color;
  logic        visible;
  logic        last;
  logic        idle;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color,
                  visible, last, idle, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color,
                  visible, last, idle, output ready);
endinterface

`default_nettype wire

// ===== rtl/blpw_cfg.sv =====
// APB register file of the line pixel writer.
// Depends on blpw_pkg.
`default_nettype none

module blpw_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [blpw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output blpw_pkg::cfg_t                   cfg
);

  blpw_pkg::cfg_t       cfg_r;
  blpw_pkg::cfg_t       cfg_nxt;
  blpw_pkg::reg_idx_t   idx;
  logic                 wr_en;

  assign idx    = blpw_pkg::reg_idx_t'(paddr[blpw_pkg::PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        blpw_pkg::REG_X_SHIFT:    cfg_nxt.x_shift    = pwdata[15:0];
        blpw_pkg::REG_Y_SHIFT:    cfg_nxt.y_shift    = pwdata[15:0];
        blpw_pkg::REG_ROW_BYTES:  cfg_nxt.row_bytes  = pwdata[15:0];
        blpw_pkg::REG_PIXEL_BITS: cfg_nxt.pixel_bits = pwdata[5:0];
        blpw_pkg::REG_FRAME_BASE: cfg_nxt.frame_base = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      blpw_pkg::REG_X_SHIFT:    prdata = {16'd0, cfg_r.x_shift};
      blpw_pkg::REG_Y_SHIFT:    prdata = {16'd0, cfg_r.y_shift};
      blpw_pkg::REG_ROW_BYTES:  prdata = {16'd0, cfg_r.row_bytes};
      blpw_pkg::REG_PIXEL_BITS: prdata = {26'd0, cfg_r.pixel_bits};
      blpw_pkg::REG_FRAME_BASE: prdata = cfg_r.frame_base;
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_shift    <= 16'd0;
      cfg_r.y_shift    <= 16'd0;
      cfg_r.row_bytes  <= 16'd4096;
      cfg_r.pixel_bits <= 6'd32;
      cfg_r.frame_base <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blpw_front.sv =====
// Front end: accepts commands and runs the Bresenham stepper, one point per
// accepted command. Depends on blpw_pkg and blpw_in_if.
`default_nettype none

module blpw_front (
  input  wire logic     clk,
  input  wire logic     rst_n,
  blpw_in_if.sink       in_item,
  input  wire logic     q_full,
  output logic          push,
  output blpw_pkg::point_t push_pt
);

  logic [15:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [15:0] cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt;
  logic [16:0] span_x_r, span_y_r, span_x_nxt, span_y_nxt;
  logic        step_x_neg_r, step_y_neg_r, step_x_neg_nxt, step_y_neg_nxt;
  logic [18:0] err_r, err_nxt;
  logic [31:0] color_r, color_nxt;
  logic        active_r, active_nxt;

  logic        accept;
  logic [16:0] dx, dy;
  logic [19:0] twice;
  logic        move_x, move_y;
  logic        at_goal;

  assign in_item.ready = ~q_full;
  assign accept        = in_item.valid & ~q_full;
  assign push          = accept;

  assign dx    = {in_item.end_x[15], in_item.end_x} - {in_item.start_x[15], in_item.start_x};
  assign dy    = {in_item.end_y[15], in_item.end_y} - {in_item.start_y[15], in_item.start_y};
  assign twice = {err_r[18], err_r} <<< 1;
  assign move_x = $signed(twice) > -$signed({3'b000, span_y_r});
  assign move_y = $signed(twice) <  $signed({3'b000, span_x_r});

  always_comb begin
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    goal_x_nxt     = goal_x_r;
    goal_y_nxt     = goal_y_r;
    span_x_nxt     = span_x_r;
    span_y_nxt     = span_y_r;
    step_x_neg_nxt = step_x_neg_r;
    step_y_neg_nxt = step_y_neg_r;
    err_nxt        = err_r;
    color_nxt      = color_r;
    active_nxt     = active_r;
    at_goal        = 1'b0;
    push_pt        = '0;

    if (!in_item.kind) begin
      // Load a new line; any active one is dropped.
      cur_x_nxt      = in_item.start_x;
      cur_y_nxt      = in_item.start_y;
      goal_x_nxt     = in_item.end_x;
      goal_y_nxt     = in_item.end_y;
      color_nxt      = in_item.line_color;
      span_x_nxt     = dx[16] ? 17'(-dx) : dx;
      span_y_nxt     = dy[16] ? 17'(-dy) : dy;
      step_x_neg_nxt = dx[16] | (dx == 17'd0);
      step_y_neg_nxt = dy[16] | (dy == 17'd0);
      err_nxt        = {2'b00, span_x_nxt} - {2'b00, span_y_nxt};
      at_goal        = (dx == 17'd0) && (dy == 17'd0);
      active_nxt     = ~at_goal;
      push_pt.cur_x  = in_item.start_x;
      push_pt.cur_y  = in_item.start_y;
      push_pt.color  = in_item.line_color;
      push_pt.last   = at_goal;
    end else if (!active_r) begin
      push_pt.idle = 1'b1;
    end else begin
      // One step: both axes may move in the same step.
      if (move_x) begin
        cur_x_nxt = step_x_neg_r ? cur_x_r - 16'd1 : cur_x_r + 16'd1;
      end
      if (move_y) begin
        cur_y_nxt = step_y_neg_r ? cur_y_r - 16'd1 : cur_y_r + 16'd1;
      end
      err_nxt = err_r - (move_x ? {2'b00, span_y_r} : 19'd0)
                      + (move_y ? {2'b00, span_x_r} : 19'd0);
      at_goal       = (cur_x_nxt == goal_x_r) && (cur_y_nxt == goal_y_r);
      active_nxt    = ~at_goal;
      push_pt.cur_x = cur_x_nxt;
      push_pt.cur_y = cur_y_nxt;
      push_pt.color = color_r;
      push_pt.last  = at_goal;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= 16'd0;
      cur_y_r      <= 16'd0;
      goal_x_r     <= 16'd0;
      goal_y_r     <= 16'd0;
      span_x_r     <= 17'd0;
      span_y_r     <= 17'd0;
      step_x_neg_r <= 1'b0;
      step_y_neg_r <= 1'b0;
      err_r        <= 19'd0;
      color_r      <= 32'd0;
      active_r     <= 1'b0;
    end else if (accept) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      goal_x_r     <= goal_x_nxt;
      goal_y_r     <= goal_y_nxt;
      span_x_r     <= span_x_nxt;
      span_y_r     <= span_y_nxt;
      step_x_neg_r <= step_x_neg_nxt;
      step_y_neg_r <= step_y_neg_nxt;
      err_r        <= err_nxt;
      color_r      <= color_nxt;
      active_r     <= active_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blpw_queue.sv =====
// Short point queue between the stepper and the address pipeline.
// Depends on blpw_pkg.
`default_nettype none

module blpw_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire blpw_pkg::point_t push_pt,
  output logic                  full,
  output logic                  head_valid,
  input  wire logic             pop,
  output blpw_pkg::point_t      head_pt
);

  localparam int CNT_W = blpw_pkg::QPTR_W + 1;

  blpw_pkg::point_t             mem_r [blpw_pkg::QDEPTH];
  logic [blpw_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         do_pop;

  assign full       = (count_r == CNT_W'(blpw_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_pt    = mem_r[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  always_comb begin
    count_nxt = count_r;
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + blpw_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + blpw_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blpw_back.sv =====
// Back end: translates, clips and addresses each point in a three-stage
// pipeline ending in the output register. Depends on blpw_pkg, blpw_out_if.
`default_nettype none

module blpw_back #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire blpw_pkg::cfg_t   cfg,
  input  wire logic             head_valid,
  input  wire blpw_pkg::point_t head_pt,
  output logic                  pop,
  blpw_out_if.source            out_pix
);

  localparam int SW       = blpw_pkg::SUM_W;
  localparam int OFFSET_X = (2 * SCREEN_WIDTH) / 5;
  localparam int OFFSET_Y = SCREEN_HEIGHT / 4;

  // Stage 1: translated coordinates and visibility.
  logic          s1_v_r;
  logic [SW-1:0] s1_sx_r, s1_sy_r;
  logic          s1_vis_r, s1_last_r, s1_idle_r;
  logic [31:0]   s1_color_r;
  // Stage 2: products.
  logic          s2_v_r;
  logic [16:0]   s2_sx_r, s2_sy_r;
  logic [31:0]   s2_row_r, s2_col_r, s2_color_r;
  logic          s2_vis_r, s2_last_r, s2_idle_r;
  // Output register.
  logic          o_v_r;
  logic [16:0]   o_x_r, o_y_r;
  logic [31:0]   o_addr_r, o_color_r;
  logic          o_vis_r, o_last_r, o_idle_r;

  logic          o_adv, s2_adv, s1_adv;
  logic [SW-1:0] sx, sy;
  logic          vis;
  logic [32:0]   row_prod;
  logic [19:0]   col_prod;

  assign o_adv  = ~o_v_r  | out_pix.ready;
  assign s2_adv = ~s2_v_r | o_adv;
  assign s1_adv = ~s1_v_r | s2_adv;
  assign pop    = s1_adv;

  assign sx = SW'({{(SW-16){head_pt.cur_x[15]}}, head_pt.cur_x})
            + SW'({{(SW-16){cfg.x_shift[15]}}, cfg.x_shift}) + SW'(OFFSET_X);
  assign sy = SW'({{(SW-16){head_pt.cur_y[15]}}, head_pt.cur_y})
            + SW'({{(SW-16){cfg.y_shift[15]}}, cfg.y_shift}) + SW'(OFFSET_Y);
  assign vis = ($signed(sx) > $signed(SW'(0))) && ($signed(sx) < $signed(SW'(SCREEN_WIDTH)))
            && ($signed(sy) > $signed(SW'(0))) && ($signed(sy) < $signed(SW'(SCREEN_HEIGHT)));

  assign row_prod = {16'd0, s1_sy_r[16:0]} * {17'd0, cfg.row_bytes};
  assign col_prod = s1_sx_r[16:0] * {17'd0, cfg.pixel_bits[5:3]};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      // An idle report carries zeros in every other field.
      s1_sx_r    <= head_pt.idle ? '0 : sx;
      s1_sy_r    <= head_pt.idle ? '0 : sy;
      s1_vis_r   <= ~head_pt.idle & vis;
      s1_last_r  <= ~head_pt.idle & head_pt.last;
      s1_idle_r  <= head_pt.idle;
      s1_color_r <= head_pt.idle ? 32'd0 : head_pt.color;
    end
    if (s2_adv) begin
      s2_sx_r    <= s1_sx_r[16:0];
      s2_sy_r    <= s1_sy_r[16:0];
      s2_row_r   <= row_prod[31:0];
      s2_col_r   <= {12'd0, col_prod};
      s2_vis_r   <= s1_vis_r;
      s2_last_r  <= s1_last_r;
      s2_idle_r  <= s1_idle_r;
      s2_color_r <= s1_color_r;
    end
    if (o_adv) begin
      o_x_r     <= s2_sx_r;
      o_y_r     <= s2_sy_r;
      o_addr_r  <= s2_vis_r ? cfg.frame_base + s2_row_r + s2_col_r : 32'd0;
      o_color_r <= s2_color_r;
      o_vis_r   <= s2_vis_r;
      o_last_r  <= s2_last_r;
      o_idle_r  <= s2_idle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= head_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (o_adv) begin
        o_v_r <= s2_v_r;
      end
    end
  end

  assign out_pix.valid         = o_v_r;
  assign out_pix.pixel_x       = o_x_r;
  assign out_pix.pixel_y       = o_y_r;
  assign out_pix.pixel_address = o_addr_r;
  assign out_pix.pixel_color   = o_color_r;
  assign out_pix.visible       = o_vis_r;
  assign out_pix.last          = o_last_r;
  assign out_pix.idle          = o_idle_r;

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_pixel_writer_core.sv =====
// Top level of the Bresenham line pixel writer: stepper front end, point
// queue, address back end and APB registers. Depends on blpw_pkg, blpw_if.
//
//  Channel  | Port     | Direction | Moves per transfer
//  ---------+----------+-----------+-----------------------------------------
//  command  | in_item  | sink      | kind, endpoints, line color
//  pixel    | out_pix  | source    | screen x/y, byte address, color, flags
//  config   | p* (APB) | slave     | one 32-bit register write or read
//
// Throughput is one command per clock while the queue is not full: the
// stepper does one add/compare update of the error term per transfer. A pixel
// passes from its command through the queue write, translate/clip, multiply
// and the address sum into the output register. The 4-entry queue decouples
// the stepper from the back end, so commands keep flowing while the output is
// stalled until the queue fills. Reset (rst_n low, synchronous) drops any
// active line and restores register defaults; no clearing pass is needed.
`default_nettype none

module bresenham_line_pixel_writer_core #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  blpw_in_if.sink                           in_item,
  blpw_out_if.source                        out_pix,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [blpw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  blpw_pkg::cfg_t   cfg;
  blpw_pkg::point_t push_pt, head_pt;
  logic             push, q_full, head_valid, pop;

  // Register file; the user must write it only while no line work is in flight; the block does not enforce this.
  blpw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stepper: one point per accepted command, holds ready low when queue full.
  blpw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .q_full  (q_full),
    .push    (push),
    .push_pt (push_pt)
  );

  blpw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_pt    (push_pt),
    .full       (q_full),
    .head_valid (head_valid),
    .pop        (pop),
    .head_pt    (head_pt)
  );

  // Translate, clip and address; advance only when the next stage frees up.
  blpw_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_pt    (head_pt),
    .pop        (pop),
    .out_pix    (out_pix)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for bresenham_line_pixel_writer_core: line commands checked against
// an in-bench Bresenham stepper and framebuffer address predictor.
// Depends on blpw_pkg, blpw_in_if, blpw_out_if and the core RTL.

module tb;

  localparam int SCREEN_W     = 1024;
  localparam int SCREEN_H     = 768;
  localparam int OFS_X        = (2 * SCREEN_W) / 5;
  localparam int OFS_Y        = SCREEN_H / 4;
  localparam int PIPE_LATENCY = 4;
  localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 540;

  localparam logic       KIND_START   = 1'b0;
  localparam logic       KIND_STEP    = 1'b1;
  // First index past the register map; writes there must change nothing.
  localparam logic [2:0] REG_UNMAPPED = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [31:0] color;
  } line_cmd_t;

  typedef struct packed {
    logic [16:0] px;
    logic [16:0] py;
    logic [31:0] addr;
    logic [31:0] color;
    logic        vis;
    logic        last;
    logic        idle;
  } pixel_t;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [blpw_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  blpw_in_if  in_ch ();
  blpw_out_if out_ch ();

  bresenham_line_pixel_writer_core #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_ch),
    .out_pix (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register image as the predictor sees it.
  logic signed [15:0] xs_cfg;
  logic signed [15:0] ys_cfg;
  logic [15:0]        row_cfg;
  logic [5:0]         bpp_cfg;
  logic [31:0]        base_cfg;

  // Stepper state of the predictor.
  logic signed [15:0] pen_x, pen_y, goal_x, goal_y;
  int                 span_x, span_y, err_acc;
  logic               x_back, y_back;
  logic [31:0]        ink;
  logic               drawing;

  line_cmd_t pending_cmds[$];
  pixel_t    expected_pixels[$];
  line_cmd_t offered;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req_cnt;
  int hold_done_cnt;
  int hold_left;
  int mismatch_count;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Translate, clip and address the current pen position.
  function automatic pixel_t place_pen(input logic at_end);
    int     sx, sy;
    pixel_t p;
    sx = int'(pen_x) + int'(xs_cfg) + OFS_X;
    sy = int'(pen_y) + int'(ys_cfg) + OFS_Y;
    p = '0;
    p.px    = sx[16:0];
    p.py    = sy[16:0];
    p.color = ink;
    p.last  = at_end;
    // Row zero and column zero stay outside the window.
    p.vis   = (sx > 0) && (sx < SCREEN_W) && (sy > 0) && (sy < SCREEN_H);
    if (p.vis) begin
      p.addr = base_cfg + 32'(sy) * 32'(row_cfg) + 32'(sx) * 32'(bpp_cfg >> 3);
    end
    return p;
  endfunction

  // Advance the predictor by one command and return the pixel it produces.
  function automatic pixel_t next_pixel(input line_cmd_t c);
    int     dx, dy, twice;
    logic   at_end;
    pixel_t idle_pix;
    if (c.kind == KIND_START) begin
      // A start drops whatever line was in progress.
      pen_x   = c.x0;
      pen_y   = c.y0;
      goal_x  = c.x1;
      goal_y  = c.y1;
      ink     = c.color;
      dx      = int'(goal_x) - int'(pen_x);
      dy      = int'(goal_y) - int'(pen_y);
      span_x  = (dx < 0) ? -dx : dx;
      span_y  = (dy < 0) ? -dy : dy;
      x_back  = !(pen_x < goal_x);
      y_back  = !(pen_y < goal_y);
      err_acc = span_x - span_y;
      at_end  = (pen_x == goal_x) && (pen_y == goal_y);
      drawing = !at_end;
      return place_pen(at_end);
    end
    if (!drawing) begin
      idle_pix      = '0;
      idle_pix.idle = 1'b1;
      return idle_pix;
    end
    twice = 2 * err_acc;
    if (twice > -span_y) begin
      err_acc = err_acc - span_y;
      pen_x   = pen_x + (x_back ? -16'sd1 : 16'sd1);
    end
    if (twice < span_x) begin
      err_acc = err_acc + span_x;
      pen_y   = pen_y + (y_back ? -16'sd1 : 16'sd1);
    end
    at_end = (pen_x == goal_x) && (pen_y == goal_y);
    if (at_end) begin
      drawing = 1'b0;
    end
    return place_pen(at_end);
  endfunction

  function automatic line_cmd_t rand_cmd(input logic kind);
    line_cmd_t c;
    c.kind  = kind;
    c.x0    = 16'($urandom);
    c.y0    = 16'($urandom);
    c.x1    = 16'($urandom);
    c.y1    = 16'($urandom);
    c.color = $urandom;
    return c;
  endfunction

  function automatic void push_line(input int x0, input int y0, input int x1, input int y1,
                                    input logic [31:0] color);
    line_cmd_t c;
    c.kind  = KIND_START;
    c.x0    = x0[15:0];
    c.y0    = y0[15:0];
    c.x1    = x1[15:0];
    c.y1    = y1[15:0];
    c.color = color;
    pending_cmds.push_back(c);
  endfunction

  function automatic void push_steps(input int n);
    repeat (n) pending_cmds.push_back(rand_cmd(KIND_STEP));
  endfunction

  // Mostly complete lines near the visible window, plus truncated lines,
  // overrun steps, long lines and lone noise commands.
  task automatic add_random_lines(input int count);
    int        added, x0, y0, adx, ady, len, steps;
    line_cmd_t c;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 8) begin
        pending_cmds.push_back(rand_cmd(1'($urandom_range(1))));
        added++;
      end else begin
        if ($urandom_range(19) == 0) begin
          c = rand_cmd(KIND_START);
        end else begin
          c = rand_cmd(KIND_START);
          x0 = int'($urandom_range(1100)) - 450 - int'(xs_cfg);
          y0 = int'($urandom_range(900)) - 300 - int'(ys_cfg);
          c.x0 = x0[15:0];
          c.y0 = y0[15:0];
          c.x1 = c.x0 + 16'(int'($urandom_range(48)) - 24);
          c.y1 = c.y0 + 16'(int'($urandom_range(48)) - 24);
        end
        adx = int'($signed(c.x1)) - int'($signed(c.x0));
        ady = int'($signed(c.y1)) - int'($signed(c.y0));
        if (adx < 0) adx = -adx;
        if (ady < 0) ady = -ady;
        len = (adx > ady) ? adx : ady;
        if (len > 64) begin
          steps = $urandom_range(6);
        end else begin
          case ($urandom_range(9))
            8:       steps = $urandom_range(len);
            9:       steps = len + $urandom_range(3, 1);
            default: steps = len;
          endcase
        end
        pending_cmds.push_back(c);
        push_steps(steps);
        added += steps + 1;
      end
    end
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      blpw_pkg::REG_X_SHIFT:    xs_cfg   = value[15:0];
      blpw_pkg::REG_Y_SHIFT:    ys_cfg   = value[15:0];
      blpw_pkg::REG_ROW_BYTES:  row_cfg  = value[15:0];
      blpw_pkg::REG_PIXEL_BITS: bpp_cfg  = value[5:0];
      blpw_pkg::REG_FRAME_BASE: base_cfg = value;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [15:0] xs, input logic [15:0] ys,
                              input logic [15:0] row, input logic [5:0] bpp,
                              input logic [31:0] base);
    write_reg(blpw_pkg::REG_X_SHIFT, {{16{xs[15]}}, xs});
    write_reg(blpw_pkg::REG_Y_SHIFT, {{16{ys[15]}}, ys});
    write_reg(blpw_pkg::REG_ROW_BYTES, {16'd0, row});
    write_reg(blpw_pkg::REG_PIXEL_BITS, {26'd0, bpp});
    write_reg(blpw_pkg::REG_FRAME_BASE, base);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Wait until every command is through and every pixel has been checked.
  task automatic drain();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Command driver: run the predictor on each transfer, then offer the next
  // pending command unless this cycle idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        // Predict in transfer order so the queue stays in pixel order.
        expected_pixels.push_back(next_pixel(offered));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_cmds.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.kind       <= offered.kind;
          in_ch.start_x    <= offered.x0;
          in_ch.start_y    <= offered.y0;
          in_ch.end_x      <= offered.x1;
          in_ch.end_y      <= offered.y1;
          in_ch.line_color <= offered.color;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: compare each transfer with the oldest expectation and
  // drive ready, holding it low for a long stretch when asked.
  always @(posedge clk) begin : pixel_monitor
    pixel_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel: expected none, actual x=%h y=%h addr=%h idle=%b",
                   $time, out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_address,
                   out_ch.idle);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", 32'(want.px), 32'(out_ch.pixel_x));
          check_field("pixel_y", 32'(want.py), 32'(out_ch.pixel_y));
          check_field("pixel_address", want.addr, out_ch.pixel_address);
          check_field("pixel_color", want.color, out_ch.pixel_color);
          check_field("visible", 32'(want.vis), 32'(out_ch.visible));
          check_field("last", 32'(want.last), 32'(out_ch.last));
          check_field("idle", 32'(want.idle), 32'(out_ch.idle));
        end
      end
      if (hold_left == 0 && hold_done_cnt != hold_req_cnt) begin
        hold_left = HOLD_CYCLES;
        hold_done_cnt++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_START;
    in_ch.start_x    = '0;
    in_ch.start_y    = '0;
    in_ch.end_x      = '0;
    in_ch.end_y      = '0;
    in_ch.line_color = '0;
    out_ch.ready     = 1'b0;
    send_idle_pct  = 18;
    recv_idle_pct  = 77;
    hold_req_cnt   = 0;
    hold_done_cnt  = 0;
    hold_left      = 0;
    mismatch_count = 0;
    // Register defaults and cleared stepper after reset.
    xs_cfg   = '0;
    ys_cfg   = '0;
    row_cfg  = 16'd4096;
    bpp_cfg  = 6'd32;
    base_cfg = '0;
    pen_x    = '0;
    pen_y    = '0;
    goal_x   = '0;
    goal_y   = '0;
    span_x   = 0;
    span_y   = 0;
    err_acc  = 0;
    x_back   = 1'b0;
    y_back   = 1'b0;
    ink      = '0;
    drawing  = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines on the reset defaults.
    push_steps(1);                                         // step with no line
    push_line(0, 0, 0, 0, 32'hFFFF_FFFF);                  // single-point line
    push_steps(1);                                         // nothing left active
    push_line(-409, -192, -406, -190, 32'h0000_0000);      // column and row zero
    push_steps(3);
    push_line(614, 575, 616, 577, 32'h5A5A_A5A5);          // right and bottom edge
    push_steps(2);
    push_line(10, 10, 13, 20, 32'h1234_5678);              // dropped mid-line
    push_steps(2);
    push_line(-5, 8, -8, 5, 32'h8000_0001);                // backward diagonal
    push_steps(4);                                         // last one runs idle
    drain();

    // Extreme registers: coordinates overflow 17 bits, addresses wrap.
    write_config(16'sh7FFF, 16'sh8000, 16'hFFFF, 6'd8, 32'hFFFF_F000);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    push_line(32767, -32768, 32767, -32766, 32'hFFFF_FFFF);
    push_steps(2);
    push_line(-32768, 32767, 32767, -32768, 32'h0000_0000);  // widest spans
    push_steps(2);
    push_line(-32768, 32767, -32767, 32767, 32'hC3C3_3C3C);
    push_steps(1);
    drain();

    // Random phase: sender idles little, receiver a lot.
    write_config(16'(int'($urandom_range(600)) - 300), 16'(int'($urandom_range(400)) - 200),
                 16'($urandom), 6'($urandom_range(32, 8)), $urandom);
    set_idling(18, 77);
    add_random_lines(PHASE_ITEMS);
    drain();

    // Random phase: sender idles a lot, receiver little; zero row pitch.
    write_config(16'(-int'($urandom_range(200))), 16'($urandom_range(150)), 16'd0, 6'd24,
                 32'hFFFF_FFFF);
    set_idling(77, 18);
    add_random_lines(PHASE_ITEMS);
    drain();

    // Full rate, with one long receiver hold to back up the pipeline.
    write_config(16'd0, 16'd0, 16'd4096, 6'd32, 32'd0);
    set_idling(0, 0);
    add_random_lines(PHASE_ITEMS);
    @(negedge clk);
    hold_req_cnt++;
    drain();

    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
